FILE: src/tcw_pkg.sv
`timescale 1ns / 1ps

package tcw_pkg;

	// Default screen geometry and tab spacing.
	localparam int DEF_COLUMNS  = 80;
	localparam int DEF_ROWS     = 25;
	localparam int DEF_TAB_STOP = 4;

	// Fixed field widths of the request and response.
	localparam int CMD_W   = 2;
	localparam int CHAR_W  = 8;
	localparam int COLIN_W = 7;
	localparam int ROWIN_W = 5;
	localparam int POS_W   = 11;
	localparam int CELL_W  = 16;
	localparam int COLOR_W = 8;

	// Request command codes.
	localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SET   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

	// Control characters and the blank glyph.
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
	localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
	localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
	localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

	// Attribute used after reset: light grey on black.
	localparam logic [COLOR_W-1:0] RESET_COLOR = 8'd7;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [CHAR_W-1:0]  char_code;
		logic [COLIN_W-1:0] col_in;
		logic [ROWIN_W-1:0] row_in;
	} tcw_item_t;

	typedef struct packed {
		logic [POS_W-1:0]   cursor_pos;
		logic [COLIN_W-1:0] cursor_col;
		logic [ROWIN_W-1:0] cursor_row;
		logic [CELL_W-1:0]  cell_data;
	} tcw_result_t;

	// Cursor update selected by the controller.
	typedef enum logic [2:0] {
		CUR_HOLD,
		CUR_SET,
		CUR_ZERO,
		CUR_CR,
		CUR_NEXTLINE,
		CUR_ADVANCE,
		CUR_BACK
	} cur_op_t;

	// Single cell write selected by the controller.
	typedef enum logic [1:0] {
		WR_NONE,
		WR_CHAR,
		WR_SPACE,
		WR_BACK
	} wr_op_t;

	typedef struct packed {
		logic    accept;
		cur_op_t cur_op;
		wr_op_t  wr_op;
		logic    rd_cell;
		logic    data_load;
		logic    sweep_start;
		logic    sweep_scroll;
		logic    sweep_reset_color;
		logic    sweep_step;
		logic    tab_init;
		logic    tab_reduce;
		logic    tab_inc;
		logic    out_load;
	} tcw_cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0] op;
		logic             is_nl;
		logic             is_cr;
		logic             is_tab;
		logic             is_bs;
		logic             col_zero;
		logic             line_last;
		logic             adv_scroll;
		logic             rd_ok;
		logic             sweep_last;
		logic             tab_reduce_more;
		logic             tab_last;
	} tcw_stat_t;

endpackage

FILE: src/tcw_dp.sv
`timescale 1ns / 1ps

module tcw_dp #(
	parameter int COLUMNS  = tcw_pkg::DEF_COLUMNS,
	parameter int ROWS     = tcw_pkg::DEF_ROWS,
	parameter int TAB_STOP = tcw_pkg::DEF_TAB_STOP
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wen,
	input  logic [tcw_pkg::COLOR_W-1:0]  cfg_data,
	input  tcw_pkg::tcw_item_t           item_in,
	input  tcw_pkg::tcw_cmd_t            cmd,
	output tcw_pkg::tcw_stat_t           stat,
	output tcw_pkg::tcw_result_t         result
);
	import tcw_pkg::*;

	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);
	localparam int COL_W      = $clog2(COLUMNS);
	localparam int LINE_W     = $clog2(ROWS);
	localparam int REM_W      = COL_W + 1;

	logic [CELL_W-1:0]  mem [CELL_COUNT];

	logic [COLOR_W-1:0] color_q;
	logic [COL_W-1:0]   col_q;
	logic [LINE_W-1:0]  line_q;
	tcw_item_t          item_q;
	logic [REM_W-1:0]   rem_q;
	logic [ADDR_W-1:0]  sweep_q;
	logic               scroll_mode_q;
	logic [CELL_W-1:0]  fill_q;
	logic [CELL_W-1:0]  rd_q;
	logic [CELL_W-1:0]  data_q;
	tcw_result_t        result_q;

	logic               we_s1;
	logic [ADDR_W-1:0]  wa_s1;
	logic [CELL_W-1:0]  wd_s1;
	logic               from_mem_s1;

	logic [ADDR_W-1:0]  cur_idx;
	logic [ADDR_W-1:0]  cell_addr;
	logic [ADDR_W-1:0]  sweep_src;
	logic               sweep_copy;
	logic               col_last;
	logic               line_last;
	logic [COL_W-1:0]   col_sat;
	logic [LINE_W-1:0]  line_sat;
	logic [COL_W-1:0]   col_d;
	logic [LINE_W-1:0]  line_d;
	logic [LINE_W-1:0]  line_inc;
	logic               re;
	logic [ADDR_W-1:0]  ra;
	logic               we_d;
	logic [ADDR_W-1:0]  wa_d;
	logic [CELL_W-1:0]  wd_d;
	logic               from_mem_d;

	assign cur_idx   = ADDR_W'(line_q) * ADDR_W'(COLUMNS) + ADDR_W'(col_q);
	assign cell_addr = ADDR_W'(item_q.row_in) * ADDR_W'(COLUMNS) + ADDR_W'(item_q.col_in);
	assign sweep_src = sweep_q + ADDR_W'(COLUMNS);
	assign sweep_copy = scroll_mode_q && (32'(sweep_q) < CELL_COUNT - COLUMNS);
	assign col_last  = (col_q == COL_W'(COLUMNS - 1));
	assign line_last = (line_q == LINE_W'(ROWS - 1));
	assign line_inc  = line_last ? line_q : line_q + 1'b1;

	assign col_sat  = (32'(item_q.col_in) < COLUMNS) ? COL_W'(item_q.col_in)
		: COL_W'(COLUMNS - 1);
	assign line_sat = (32'(item_q.row_in) < ROWS) ? LINE_W'(item_q.row_in)
		: LINE_W'(ROWS - 1);

	always_comb begin
		col_d  = col_q;
		line_d = line_q;
		case (cmd.cur_op)
			CUR_HOLD: begin
			end
			CUR_SET: begin
				col_d  = col_sat;
				line_d = line_sat;
			end
			CUR_ZERO: begin
				col_d  = '0;
				line_d = '0;
			end
			CUR_CR: begin
				col_d = '0;
			end
			CUR_NEXTLINE: begin
				col_d  = '0;
				line_d = line_inc;
			end
			CUR_ADVANCE: begin
				if (col_last) begin
					col_d  = '0;
					line_d = line_inc;
				end else begin
					col_d = col_q + 1'b1;
				end
			end
			CUR_BACK: begin
				col_d = col_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Read port: one cell read, or the source row of a scroll copy.
	always_comb begin
		re = 1'b0;
		ra = cell_addr;
		if (cmd.rd_cell) begin
			re = 1'b1;
		end else if (cmd.sweep_step && sweep_copy) begin
			re = 1'b1;
			ra = sweep_src;
		end
	end

	// Write port request, issued into the write stage.
	always_comb begin
		we_d       = 1'b0;
		wa_d       = cur_idx;
		wd_d       = {color_q, CH_SPACE};
		from_mem_d = 1'b0;
		if (cmd.sweep_step) begin
			we_d       = 1'b1;
			wa_d       = sweep_q;
			wd_d       = fill_q;
			from_mem_d = sweep_copy;
		end else begin
			case (cmd.wr_op)
				WR_NONE: begin
				end
				WR_CHAR: begin
					we_d = 1'b1;
					wd_d = {color_q, item_q.char_code};
				end
				WR_SPACE: begin
					we_d = 1'b1;
				end
				WR_BACK: begin
					we_d = 1'b1;
					wa_d = cur_idx - 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd_q <= mem[ra];
		end
	end

	always_ff @(posedge clk) begin
		if (we_s1) begin
			mem[wa_s1] <= from_mem_s1 ? rd_q : wd_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= RESET_COLOR;
			col_q   <= '0;
			line_q  <= '0;
			we_s1   <= 1'b0;
		end else begin
			if (cfg_wen) begin
				color_q <= cfg_data;
			end
			col_q  <= col_d;
			line_q <= line_d;
			we_s1  <= we_d;
		end
	end

	always_ff @(posedge clk) begin
		wa_s1       <= wa_d;
		wd_s1       <= wd_d;
		from_mem_s1 <= from_mem_d;
		if (cmd.accept) begin
			item_q <= item_in;
			data_q <= '0;
		end
		if (cmd.data_load) begin
			data_q <= rd_q;
		end
		if (cmd.tab_init) begin
			rem_q <= REM_W'(col_q);
		end else if (cmd.tab_reduce) begin
			rem_q <= rem_q - REM_W'(TAB_STOP);
		end else if (cmd.tab_inc) begin
			rem_q <= rem_q + 1'b1;
		end
		if (cmd.sweep_start) begin
			sweep_q       <= '0;
			scroll_mode_q <= cmd.sweep_scroll;
			fill_q        <= {cmd.sweep_reset_color ? RESET_COLOR : color_q, CH_SPACE};
		end else if (cmd.sweep_step) begin
			sweep_q <= sweep_q + 1'b1;
		end
		if (cmd.out_load) begin
			result_q.cursor_pos <= POS_W'(cur_idx);
			result_q.cursor_col <= COLIN_W'(col_q);
			result_q.cursor_row <= ROWIN_W'(line_q);
			result_q.cell_data  <= data_q;
		end
	end

	assign result = result_q;

	always_comb begin
		stat.op              = item_q.cmd;
		stat.is_nl           = (item_q.char_code == CH_NEWLINE);
		stat.is_cr           = (item_q.char_code == CH_RETURN);
		stat.is_tab          = (item_q.char_code == CH_TAB);
		stat.is_bs           = (item_q.char_code == CH_BACKSPACE);
		stat.col_zero        = (col_q == '0);
		stat.line_last       = line_last;
		stat.adv_scroll      = col_last && line_last;
		stat.rd_ok           = (32'(item_q.col_in) < COLUMNS) && (32'(item_q.row_in) < ROWS);
		stat.sweep_last      = (sweep_q == ADDR_W'(CELL_COUNT - 1));
		stat.tab_reduce_more = (32'(rem_q) >= TAB_STOP);
		stat.tab_last        = (32'(rem_q) == TAB_STOP - 1);
	end

endmodule

FILE: src/tcw_ctrl.sv
`timescale 1ns / 1ps

module tcw_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	input  tcw_pkg::tcw_stat_t stat,
	output tcw_pkg::tcw_cmd_t  cmd
);
	import tcw_pkg::*;

	typedef enum logic [2:0] {
		S_BOOT,
		S_IDLE,
		S_EXEC,
		S_TABMOD,
		S_TAB,
		S_SWEEP,
		S_RDWAIT
	} state_t;

	state_t state_q, state_d;
	logic   boot_q, boot_d;
	logic   tab_more_q, tab_more_d;
	logic   res_pend_q, res_pend_d;
	logic   rsp_valid_q, rsp_valid_d;
	logic   out_free;
	logic   out_blocked;

	assign out_free    = !rsp_valid_q || !rsp_stall;
	assign out_blocked = res_pend_q && !out_free;
	assign req_stall   = (state_q != S_IDLE) || out_blocked;
	assign rsp_valid   = rsp_valid_q;

	always_comb begin
		cmd        = '0;
		state_d    = state_q;
		boot_d     = boot_q;
		tab_more_d = tab_more_q;
		res_pend_d = res_pend_q;
		case (state_q)
			S_BOOT: begin
				cmd.sweep_start       = 1'b1;
				cmd.sweep_reset_color = 1'b1;
				boot_d                = 1'b1;
				tab_more_d            = 1'b0;
				state_d               = S_SWEEP;
			end
			S_IDLE: begin
				if (res_pend_q && out_free) begin
					cmd.out_load = 1'b1;
					res_pend_d   = 1'b0;
				end
				if (req_valid && !out_blocked) begin
					cmd.accept = 1'b1;
					state_d    = S_EXEC;
				end
			end
			S_EXEC: begin
				res_pend_d = 1'b1;
				state_d    = S_IDLE;
				case (stat.op)
					CMD_PUT: begin
						if (stat.is_nl) begin
							cmd.cur_op = CUR_NEXTLINE;
							if (stat.line_last) begin
								cmd.sweep_start  = 1'b1;
								cmd.sweep_scroll = 1'b1;
								boot_d           = 1'b0;
								tab_more_d       = 1'b0;
								res_pend_d       = 1'b0;
								state_d          = S_SWEEP;
							end
						end else if (stat.is_cr) begin
							cmd.cur_op = CUR_CR;
						end else if (stat.is_tab) begin
							cmd.tab_init = 1'b1;
							res_pend_d   = 1'b0;
							state_d      = S_TABMOD;
						end else if (stat.is_bs) begin
							if (!stat.col_zero) begin
								cmd.wr_op  = WR_BACK;
								cmd.cur_op = CUR_BACK;
							end
						end else begin
							cmd.wr_op  = WR_CHAR;
							cmd.cur_op = CUR_ADVANCE;
							if (stat.adv_scroll) begin
								cmd.sweep_start  = 1'b1;
								cmd.sweep_scroll = 1'b1;
								boot_d           = 1'b0;
								tab_more_d       = 1'b0;
								res_pend_d       = 1'b0;
								state_d          = S_SWEEP;
							end
						end
					end
					CMD_SET: begin
						cmd.cur_op = CUR_SET;
					end
					CMD_CLEAR: begin
						cmd.cur_op      = CUR_ZERO;
						cmd.sweep_start = 1'b1;
						boot_d          = 1'b0;
						tab_more_d      = 1'b0;
						res_pend_d      = 1'b0;
						state_d         = S_SWEEP;
					end
					CMD_READ: begin
						if (stat.rd_ok) begin
							cmd.rd_cell = 1'b1;
							res_pend_d  = 1'b0;
							state_d     = S_RDWAIT;
						end
					end
					default: begin
					end
				endcase
			end
			S_TABMOD: begin
				if (stat.tab_reduce_more) begin
					cmd.tab_reduce = 1'b1;
				end else begin
					state_d = S_TAB;
				end
			end
			S_TAB: begin
				cmd.wr_op   = WR_SPACE;
				cmd.cur_op  = CUR_ADVANCE;
				cmd.tab_inc = 1'b1;
				if (stat.adv_scroll) begin
					cmd.sweep_start  = 1'b1;
					cmd.sweep_scroll = 1'b1;
					boot_d           = 1'b0;
					tab_more_d       = !stat.tab_last;
					state_d          = S_SWEEP;
				end else if (stat.tab_last) begin
					res_pend_d = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_SWEEP: begin
				cmd.sweep_step = 1'b1;
				if (stat.sweep_last) begin
					if (boot_q) begin
						boot_d  = 1'b0;
						state_d = S_IDLE;
					end else if (tab_more_q) begin
						state_d = S_TAB;
					end else begin
						res_pend_d = 1'b1;
						state_d    = S_IDLE;
					end
				end
			end
			S_RDWAIT: begin
				cmd.data_load = 1'b1;
				res_pend_d    = 1'b1;
				state_d       = S_IDLE;
			end
			default: begin
				state_d = S_BOOT;
			end
		endcase
		rsp_valid_d = cmd.out_load ? 1'b1 : (rsp_valid_q && rsp_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_BOOT;
			boot_q      <= 1'b0;
			tab_more_q  <= 1'b0;
			res_pend_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			boot_q      <= boot_d;
			tab_more_q  <= tab_more_d;
			res_pend_q  <= res_pend_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

endmodule

FILE: src/text_console_writer.sv
`timescale 1ns / 1ps

// Channel    Direction  Handshake              Payload
// cfg        in         cfg_wen                cfg_data (text colour attribute)
// req        in         req_valid / req_stall  req (cmd, char_code, col_in, row_in)
// rsp        out        rsp_valid / rsp_stall  rsp (cursor_pos, cursor_col, cursor_row, cell_data)
//
// A plain character, carriage return, backspace or set-cursor request is first taken in
// the idle state and then executed. A cell read on the screen also waits for the cell
// store's read data, as it is registered; a read off the screen skips the store. Clear
// sweeps every cell and any scroll adds a sweep of the whole store, which has one read
// port and one write port and is swept one cell per cycle. A tab first finds its phase
// by subtracting TAB_STOP from the column, then writes spaces up to the next tab stop.
// After reset a clearing pass fills the store with blanks and req_stall stays high
// throughout. A stalled response sits in the output register while the next request
// is already being executed.

module text_console_writer #(
	parameter int COLUMNS  = tcw_pkg::DEF_COLUMNS,
	parameter int ROWS     = tcw_pkg::DEF_ROWS,
	parameter int TAB_STOP = tcw_pkg::DEF_TAB_STOP
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wen,
	input  logic [tcw_pkg::COLOR_W-1:0] cfg_data,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  tcw_pkg::tcw_item_t          req,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output tcw_pkg::tcw_result_t        rsp
);
	import tcw_pkg::*;

	// The controller sequences every request; the datapath holds the cell store,
	// the cursor, the sweep counter used for clearing and scrolling, and the
	// output register that parts the two channels.
	tcw_cmd_t  dp_cmd;
	tcw_stat_t dp_stat;

	tcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.stat      (dp_stat),
		.cmd       (dp_cmd)
	);

	tcw_dp #(
		.COLUMNS  (COLUMNS),
		.ROWS     (ROWS),
		.TAB_STOP (TAB_STOP)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_data (cfg_data),
		.item_in  (req),
		.cmd      (dp_cmd),
		.stat     (dp_stat),
		.result   (rsp)
	);

`ifndef NO_ASSERTIONS
	// The reported cursor always lies on the screen.
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (32'(rsp.cursor_col) < COLUMNS) && (32'(rsp.cursor_row) < ROWS))
		else $error("cursor outside the screen");

	// No request is taken while the store is being swept.
	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |-> !dp_cmd.sweep_step)
		else $error("request taken during a sweep");

	// The single write port is used by at most one source per cycle.
	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({dp_cmd.wr_op != WR_NONE, dp_cmd.sweep_step}))
		else $error("write port conflict");

	// Loading the output register always presents a response next cycle.
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.out_load |=> rsp_valid)
		else $error("loaded response not presented");
`endif

endmodule
